/* rtl/i2c_mts_pkg.sv */
package i2c_mts_pkg;

  // command codes
  localparam logic [1:0] CMD_LOAD     = 2'd0;
  localparam logic [1:0] CMD_START_WR = 2'd1;
  localparam logic [1:0] CMD_START_RD = 2'd2;
  localparam logic [1:0] CMD_EVENT    = 2'd3;

  // bus actions
  localparam logic [1:0] ACT_NONE     = 2'd0;
  localparam logic [1:0] ACT_START    = 2'd1;
  localparam logic [1:0] ACT_CONTINUE = 2'd2;
  localparam logic [1:0] ACT_STOP     = 2'd3;

  // request status
  localparam logic [1:0] ST_BUSY  = 2'd0;
  localparam logic [1:0] ST_OK    = 2'd1;
  localparam logic [1:0] ST_NAK   = 2'd2;
  localparam logic [1:0] ST_ERROR = 2'd3;

  // controller state codes
  localparam logic [2:0] MS_RX_READY = 3'd1;
  localparam logic [2:0] MS_TX_READY = 3'd2;
  localparam logic [2:0] MS_NACK_ADR = 3'd3;
  localparam logic [2:0] MS_NACK_DAT = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_START    = 3'd1,
    PH_TRANSMIT = 3'd2,
    PH_RECEIVE  = 3'd3,
    PH_STOP     = 3'd4
  } phase_t;

  typedef struct packed {
    logic [1:0] command;
    logic [6:0] target_address;
    logic [7:0] transfer_length;
    logic [7:0] load_index;
    logic [7:0] load_value;
    logic       arbitration_lost;
    logic       start_stop_error;
    logic       master_pending;
    logic [2:0] master_state_code;
    logic [7:0] bus_read_data;
  } in_item_t;

  typedef struct packed {
    logic       data_write_valid;
    logic [7:0] data_write_value;
    logic [1:0] bus_action;
    logic [1:0] request_status;
    logic       transfer_done;
    logic       read_valid;
    logic [7:0] read_index;
    logic [7:0] read_value;
  } out_item_t;

  // buffer port request from the sequencer
  typedef struct packed {
    logic       wr_en;
    logic [7:0] wr_addr;
    logic [7:0] wr_data;
    logic       rd_en;
    logic [7:0] rd_addr;
  } buf_req_t;

endpackage

/* rtl/i2c_mts_buffer.sv */
module i2c_mts_buffer #(
  parameter int DEPTH = 256
) (
  input  logic                 clk,
  input  i2c_mts_pkg::buf_req_t req,
  output logic [7:0]           rd_data_r
);
  import i2c_mts_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0] mem [DEPTH];

  // write port: load beats
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
  end

  // read port: registered, held until next read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr[AW-1:0]];
    end
  end

endmodule

/* rtl/i2c_mts_ctrl.sv */
module i2c_mts_ctrl #(
  parameter int DEPTH = 256
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  i2c_mts_pkg::in_item_t  in_data,
  output i2c_mts_pkg::buf_req_t  buf_req,
  output i2c_mts_pkg::out_item_t res,
  output logic                   tx_from_buf
);
  import i2c_mts_pkg::*;

  localparam logic [8:0] DEPTH9 = 9'(DEPTH);

  phase_t     phase_r, phase_nxt;
  logic       is_write_r, is_write_nxt;
  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic [7:0] byte_pos_r, byte_pos_nxt;
  logic [6:0] slave_addr_r, slave_addr_nxt;
  logic [7:0] left_dec;
  logic       pos_ok;
  logic       load_ok;

  assign left_dec = bytes_left_r - 8'd1;
  assign pos_ok   = {1'b0, byte_pos_r} < DEPTH9;
  assign load_ok  = {1'b0, in_data.load_index} < DEPTH9;

  // buffer: store loads, read at the current transmit position every beat
  always_comb begin
    buf_req.wr_en   = accept && (in_data.command == CMD_LOAD) && load_ok;
    buf_req.wr_addr = in_data.load_index;
    buf_req.wr_data = in_data.load_value;
    buf_req.rd_en   = accept;
    buf_req.rd_addr = byte_pos_r;
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      is_write_r   <= 1'b0;
      bytes_left_r <= '0;
      byte_pos_r   <= '0;
      slave_addr_r <= '0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      is_write_r   <= is_write_nxt;
      bytes_left_r <= bytes_left_nxt;
      byte_pos_r   <= byte_pos_nxt;
      slave_addr_r <= slave_addr_nxt;
    end
  end

  // decode command and step the transfer
  always_comb begin
    phase_nxt      = phase_r;
    is_write_nxt   = is_write_r;
    bytes_left_nxt = bytes_left_r;
    byte_pos_nxt   = byte_pos_r;
    slave_addr_nxt = slave_addr_r;
    res            = '0;
    tx_from_buf    = 1'b0;

    unique case (in_data.command)
      CMD_LOAD: begin
      end
      CMD_START_WR, CMD_START_RD: begin
        slave_addr_nxt = in_data.target_address;
        bytes_left_nxt = in_data.transfer_length;
        byte_pos_nxt   = '0;
        is_write_nxt   = (in_data.command == CMD_START_WR);
        phase_nxt      = PH_START;
      end
      default: begin
        if (in_data.arbitration_lost || in_data.start_stop_error ||
            !in_data.master_pending) begin
          res.request_status = ST_ERROR;
          res.transfer_done  = 1'b1;
          phase_nxt          = PH_IDLE;
        end else if (in_data.master_state_code == MS_NACK_ADR ||
                     in_data.master_state_code == MS_NACK_DAT) begin
          res.bus_action     = ACT_STOP;
          res.request_status = ST_NAK;
          res.transfer_done  = 1'b1;
          phase_nxt          = PH_IDLE;
        end else begin
          unique case (phase_r)
            PH_START: begin
              res.data_write_valid = 1'b1;
              res.data_write_value = {slave_addr_r, !is_write_r};
              res.bus_action       = ACT_START;
              res.request_status   = ST_OK;
              if (bytes_left_r == 8'd0) begin
                phase_nxt = PH_STOP;
              end else begin
                phase_nxt = is_write_r ? PH_TRANSMIT : PH_RECEIVE;
              end
            end
            PH_TRANSMIT: begin
              if (in_data.master_state_code != MS_TX_READY) begin
                res.request_status = ST_ERROR;
                res.transfer_done  = 1'b1;
                phase_nxt          = PH_IDLE;
              end else begin
                // byte itself comes from the registered buffer read
                res.data_write_valid = 1'b1;
                tx_from_buf          = pos_ok;
                res.bus_action       = ACT_CONTINUE;
                res.request_status   = ST_OK;
                byte_pos_nxt         = byte_pos_r + 8'd1;
                bytes_left_nxt       = left_dec;
                if (left_dec == 8'd0) begin
                  phase_nxt = PH_STOP;
                end
              end
            end
            PH_RECEIVE: begin
              if (in_data.master_state_code != MS_RX_READY) begin
                res.request_status = ST_ERROR;
                res.transfer_done  = 1'b1;
                phase_nxt          = PH_IDLE;
              end else begin
                res.read_valid = 1'b1;
                res.read_index = byte_pos_r;
                res.read_value = in_data.bus_read_data;
                byte_pos_nxt   = byte_pos_r + 8'd1;
                bytes_left_nxt = left_dec;
                if (left_dec == 8'd0) begin
                  res.bus_action     = ACT_STOP;
                  res.request_status = ST_OK;
                  res.transfer_done  = 1'b1;
                  phase_nxt          = PH_IDLE;
                end else begin
                  res.bus_action     = ACT_CONTINUE;
                  res.request_status = ST_OK;
                end
              end
            end
            PH_STOP: begin
              res.bus_action     = ACT_STOP;
              res.request_status = ST_OK;
              res.transfer_done  = 1'b1;
              phase_nxt          = PH_IDLE;
            end
            default: begin
              // event while idle
              res.request_status = ST_ERROR;
              res.transfer_done  = 1'b1;
              phase_nxt          = PH_IDLE;
            end
          endcase
        end
      end
    endcase
  end

endmodule

/* rtl/i2c_master_transfer_sequencer.sv */
// I2C master transfer sequencer. Each beat on the in_ channel (load a write
// byte, start a write, start a read, or report a controller event) yields
// exactly one registered result beat on the out_ channel. One beat is taken
// every cycle as long as the result side keeps up; a result held by
// out_ready low stalls input only once the single result register is full.
// The write bytes sit in a BUFFER_DEPTH x 8 synchronous memory; a transmit
// event reads the byte at the current position on its accepting edge and
// the registered read data feeds the result directly, so loads and
// transmits may follow each other back to back. The buffer is not cleared
// at reset: the user, not the block, must read only written entries.
module i2c_master_transfer_sequencer #(
  parameter int BUFFER_DEPTH = 256
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  i2c_mts_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output i2c_mts_pkg::out_item_t out_data
);
  import i2c_mts_pkg::*;

  logic      accept;
  buf_req_t  buf_req;
  out_item_t res;
  logic      tx_from_buf;
  logic [7:0] buf_rd_data_r;

  logic      out_valid_r;
  out_item_t res_r;
  logic      tx_sel_r;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  i2c_mts_ctrl #(
    .DEPTH(BUFFER_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_data    (in_data),
    .buf_req    (buf_req),
    .res        (res),
    .tx_from_buf(tx_from_buf)
  );

  i2c_mts_buffer #(
    .DEPTH(BUFFER_DEPTH)
  ) u_buffer (
    .clk      (clk),
    .req      (buf_req),
    .rd_data_r(buf_rd_data_r)
  );

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  // result payload, held while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      res_r    <= res;
      tx_sel_r <= tx_from_buf;
    end
  end

  // merge the buffer byte into a transmit result
  always_comb begin
    out_data = res_r;
    if (tx_sel_r) begin
      out_data.data_write_value = buf_rd_data_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/i2c_mts_checker.sv */
module i2c_mts_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input i2c_mts_pkg::out_item_t out_data
);
  import i2c_mts_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // every accepted beat shows a result on the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted beat produced no result");

  // a beat never both writes the data register and delivers a read byte
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.data_write_valid && out_data.read_valid))
    else $error("write and read in one result");

  // completion always carries a final status
  a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.transfer_done |-> out_data.request_status != ST_BUSY)
    else $error("done reported with busy status");

  // idle result fields read as zero
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.read_valid |->
      out_data.read_index == 8'd0 && out_data.read_value == 8'd0)
    else $error("read fields nonzero without read beat");

endmodule

bind i2c_master_transfer_sequencer i2c_mts_checker u_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

/* bench/tb_i2c_master_transfer_sequencer.sv */
module tb_i2c_master_transfer_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import i2c_mts_pkg::*;

  localparam int RANDOM_BEATS  = 1200;
  localparam int IDLE_LIMIT    = 5000;
  localparam int SETTLE_CYCLES = 8;
  localparam int SWAP_AT       = 400;
  localparam int CALM_AT       = 800;

  // one directed row: the beat, and a hand-written result where it is obvious
  typedef struct packed {
    in_item_t  beat;
    logic      typed;
    out_item_t res;
  } plan_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // transfer sequencer state as seen by the bench
  logic [7:0] tx_buffer [256];
  bit         tx_written [256];
  phase_t     seq_phase  = PH_IDLE;
  logic       xfer_write = 1'b0;
  logic [7:0] xfer_left  = '0;
  logic [7:0] xfer_pos   = '0;
  logic [6:0] xfer_addr  = '0;

  out_item_t   expected_results[$];
  int unsigned sender_idle_pct    = 33;
  int unsigned receiver_stall_pct = 67;
  int          mismatches  = 0;
  int          idle_cycles = 0;
  int          beats_sent  = 0;

  i2c_master_transfer_sequencer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic in_item_t mk_load(input logic [7:0] idx, val);
    in_item_t b;
    b = '0;
    b.command    = CMD_LOAD;
    b.load_index = idx;
    b.load_value = val;
    return b;
  endfunction

  function automatic in_item_t mk_start(input logic [1:0] cmd, input logic [6:0] addr,
                                        input logic [7:0] len);
    in_item_t b;
    b = '0;
    b.command         = cmd;
    b.target_address  = addr;
    b.transfer_length = len;
    return b;
  endfunction

  function automatic in_item_t mk_event(input logic al, sse, pend, input logic [2:0] ms,
                                        input logic [7:0] rd);
    in_item_t b;
    b = '0;
    b.command           = CMD_EVENT;
    b.arbitration_lost  = al;
    b.start_stop_error  = sse;
    b.master_pending    = pend;
    b.master_state_code = ms;
    b.bus_read_data     = rd;
    return b;
  endfunction

  function automatic out_item_t mk_res(input logic dwv, input logic [7:0] dwval,
                                       input logic [1:0] act, st, input logic done);
    out_item_t r;
    r = '0;
    r.data_write_valid = dwv;
    r.data_write_value = dwval;
    r.bus_action       = act;
    r.request_status   = st;
    r.transfer_done    = done;
    return r;
  endfunction

  // close the transfer with a final status and bus action
  function automatic void end_transfer(inout out_item_t r, input logic [1:0] st, act);
    r.bus_action     = act;
    r.request_status = st;
    r.transfer_done  = 1'b1;
    seq_phase        = PH_IDLE;
  endfunction

  // advance the sequencer by one accepted beat and return its result
  function automatic out_item_t step_sequencer(input in_item_t b);
    out_item_t r;
    r = '0;
    case (b.command)
      CMD_LOAD: begin
        tx_buffer[b.load_index]  = b.load_value;
        tx_written[b.load_index] = 1'b1;
      end
      CMD_START_WR, CMD_START_RD: begin
        xfer_addr  = b.target_address;
        xfer_left  = b.transfer_length;
        xfer_pos   = '0;
        xfer_write = (b.command == CMD_START_WR);
        seq_phase  = PH_START;
      end
      default: begin
        if (b.arbitration_lost || b.start_stop_error || !b.master_pending) begin
          end_transfer(r, ST_ERROR, ACT_NONE);
        end else if (b.master_state_code == MS_NACK_ADR ||
                     b.master_state_code == MS_NACK_DAT) begin
          end_transfer(r, ST_NAK, ACT_STOP);
        end else begin
          case (seq_phase)
            PH_START: begin
              r.data_write_valid = 1'b1;
              r.data_write_value = {xfer_addr, ~xfer_write};
              r.bus_action       = ACT_START;
              r.request_status   = ST_OK;
              if (xfer_left == 8'd0) seq_phase = PH_STOP;
              else seq_phase = xfer_write ? PH_TRANSMIT : PH_RECEIVE;
            end
            PH_TRANSMIT: begin
              if (b.master_state_code != MS_TX_READY) begin
                end_transfer(r, ST_ERROR, ACT_NONE);
              end else begin
                r.data_write_valid = 1'b1;
                r.data_write_value = tx_buffer[xfer_pos];
                r.bus_action       = ACT_CONTINUE;
                r.request_status   = ST_OK;
                xfer_pos  = xfer_pos + 8'd1;
                xfer_left = xfer_left - 8'd1;
                if (xfer_left == 8'd0) seq_phase = PH_STOP;
              end
            end
            PH_RECEIVE: begin
              if (b.master_state_code != MS_RX_READY) begin
                end_transfer(r, ST_ERROR, ACT_NONE);
              end else begin
                r.read_valid = 1'b1;
                r.read_index = xfer_pos;
                r.read_value = b.bus_read_data;
                xfer_pos  = xfer_pos + 8'd1;
                xfer_left = xfer_left - 8'd1;
                if (xfer_left == 8'd0) begin
                  end_transfer(r, ST_OK, ACT_STOP);
                end else begin
                  r.bus_action     = ACT_CONTINUE;
                  r.request_status = ST_OK;
                end
              end
            end
            PH_STOP: end_transfer(r, ST_OK, ACT_STOP);
            default: end_transfer(r, ST_ERROR, ACT_NONE);
          endcase
        end
      end
    endcase
    return r;
  endfunction

  // pick the next random beat: mostly well-formed transfers, some noise
  function automatic in_item_t draw_beat();
    in_item_t    b;
    logic [63:0] noise;
    int unsigned roll;
    noise = {$urandom(), $urandom()};
    b     = noise[$bits(in_item_t)-1:0];
    roll  = $urandom_range(0, 99);
    if (roll < 8) begin
      // keep the fully random beat
    end else if (seq_phase == PH_IDLE || roll < 12) begin
      if ($urandom_range(0, 99) < 40) begin
        b.command = CMD_LOAD;
        if ($urandom_range(0, 3) != 0) b.load_index = 8'($urandom_range(0, 15));
      end else begin
        b.command = $urandom_range(0, 1) ? CMD_START_WR : CMD_START_RD;
        if ($urandom_range(0, 9) != 0) b.transfer_length = 8'($urandom_range(0, 6));
      end
    end else begin
      b.command          = CMD_EVENT;
      b.arbitration_lost = 1'b0;
      b.start_stop_error = 1'b0;
      b.master_pending   = 1'b1;
      if (roll < 15) begin
        b.master_state_code = $urandom_range(0, 1) ? MS_NACK_ADR : MS_NACK_DAT;
      end else begin
        case (seq_phase)
          PH_TRANSMIT: b.master_state_code = MS_TX_READY;
          PH_RECEIVE:  b.master_state_code = MS_RX_READY;
          default: begin
            do b.master_state_code = 3'($urandom_range(0, 7));
            while (b.master_state_code == MS_NACK_ADR || b.master_state_code == MS_NACK_DAT);
          end
        endcase
      end
    end
    // never transmit an unwritten buffer entry: fill it first
    if (b.command == CMD_EVENT && seq_phase == PH_TRANSMIT && !b.arbitration_lost &&
        !b.start_stop_error && b.master_pending && b.master_state_code == MS_TX_READY &&
        !tx_written[xfer_pos]) begin
      b.command    = CMD_LOAD;
      b.load_index = xfer_pos;
    end
    return b;
  endfunction

  // drive one beat, wait for acceptance, and queue its result
  task automatic send_beat(input in_item_t b, input logic typed, input out_item_t res);
    out_item_t predicted;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data  <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = step_sequencer(b);
    expected_results.push_back(typed ? res : predicted);
    beats_sent++;
    // hold off until the block has drained, then change the idle mix
    if (beats_sent == SWAP_AT || beats_sent == CALM_AT) begin
      in_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clk);
      if (beats_sent == SWAP_AT) begin
        sender_idle_pct    = 67;
        receiver_stall_pct = 33;
      end else begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want_v, got_v);
    if (got_v !== want_v) begin
      if (mismatches < 10)
        $display("mismatch in %s: expected 'h%0h, got 'h%0h", name, want_v, got_v);
      mismatches++;
    end
  endtask

  // check each result beat and stall the result side at random
  always @(posedge clk) begin
    out_item_t want;
    if (out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        if (mismatches < 10) $display("result beat with nothing expected: 'h%h", out_data);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("data_write_valid", 8'(want.data_write_valid),
                    8'(out_data.data_write_valid));
        check_field("data_write_value", want.data_write_value, out_data.data_write_value);
        check_field("bus_action", 8'(want.bus_action), 8'(out_data.bus_action));
        check_field("request_status", 8'(want.request_status),
                    8'(out_data.request_status));
        check_field("transfer_done", 8'(want.transfer_done), 8'(out_data.transfer_done));
        check_field("read_valid", 8'(want.read_valid), 8'(out_data.read_valid));
        check_field("read_index", want.read_index, out_data.read_index);
        check_field("read_value", want.read_value, out_data.read_value);
      end
    end
    out_ready <= rst_n ? ($urandom_range(0, 99) >= receiver_stall_pct) : 1'b0;
  end

  // end the run when no beat moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    plan_row_t plan[$];
    out_item_t err_done;
    out_item_t nak_done;
    err_done = mk_res(1'b0, 8'h00, ACT_NONE, ST_ERROR, 1'b1);
    nak_done = mk_res(1'b0, 8'h00, ACT_STOP, ST_NAK, 1'b1);

    // events while idle: every error check, then both NACKs
    plan.push_back('{mk_event(1'b0, 1'b0, 1'b1, MS_TX_READY, 8'h00), 1'b1, err_done});
    plan.push_back('{mk_event(1'b1, 1'b0, 1'b1, MS_RX_READY, 8'hFF), 1'b1, err_done});
    plan.push_back('{mk_event(1'b0, 1'b1, 1'b1, 3'd0, 8'h00), 1'b1, err_done});
    plan.push_back('{mk_event(1'b0, 1'b0, 1'b0, 3'd0, 8'h00), 1'b1, err_done});
    plan.push_back('{mk_event(1'b0, 1'b0, 1'b1, MS_NACK_ADR, 8'h00), 1'b1, nak_done});
    plan.push_back('{mk_event(1'b0, 1'b0, 1'b1, MS_NACK_DAT, 8'h00), 1'b1, nak_done});
    // buffer loads at the index and value extremes, then at indices one and two
    plan.push_back('{mk_load(8'd0, 8'hFF), 1'b1, out_item_t'('0)});
    plan.push_back('{mk_load(8'd255, 8'h00), 1'b1, out_item_t'('0)});
    plan.push_back('{mk_load(8'd1, 8'hA5), 1'b1, out_item_t'('0)});
    plan.push_back('{mk_load(8'd2, 8'h5A), 1'b1, out_item_t'('0)});
    // full write of three bytes to the top address
    plan.push_back('{mk_start(CMD_START_WR, 7'd127, 8'd3), 1'b1, out_item_t'('0)});
    plan.push_back('{mk_event(1'b0, 1'b0, 1'b1, MS_TX_READY, 8'h00), 1'b1,
                     mk_res(1'b1, 8'hFE, ACT_START, ST_OK, 1'b0)});
    plan.push_back('{mk_event(1'b0, 1'b0, 1'b1, MS_TX_READY, 8'h00), 1'b1,
                     mk_res(1'b1, 8'hFF, ACT_CONTINUE, ST_OK, 1'b0)});
    plan.push_back('{mk_event(1'b0, 1'b0, 1'b1, MS_TX_READY, 8'h00), 1'b0, out_item_t'('0)});
    plan.push_back('{mk_event(1'b0, 1'b0, 1'b1, MS_TX_READY, 8'h00), 1'b0, out_item_t'('0)});
    plan.push_back('{mk_event(1'b0, 1'b0, 1'b1, 3'd0, 8'h00), 1'b0, out_item_t'('0)});
    // full read of two bytes from address zero
    plan.push_back('{mk_start(CMD_START_RD, 7'd0, 8'd2), 1'b1, out_item_t'('0)});
    plan.push_back('{mk_event(1'b0, 1'b0, 1'b1, MS_TX_READY, 8'h00), 1'b1,
                     mk_res(1'b1, 8'h01, ACT_START, ST_OK, 1'b0)});
    plan.push_back('{mk_event(1'b0, 1'b0, 1'b1, MS_RX_READY, 8'hFF), 1'b0, out_item_t'('0)});
    plan.push_back('{mk_event(1'b0, 1'b0, 1'b1, MS_RX_READY, 8'h00), 1'b0, out_item_t'('0)});
    // longest read, dropped by a wrong ready state
    plan.push_back('{mk_start(CMD_START_RD, 7'h2A, 8'd255), 1'b1, out_item_t'('0)});
    plan.push_back('{mk_event(1'b0, 1'b0, 1'b1, 3'd7, 8'h00), 1'b0, out_item_t'('0)});
    plan.push_back('{mk_event(1'b0, 1'b0, 1'b1, MS_TX_READY, 8'h00), 1'b0, out_item_t'('0)});
    // zero length, then restart in the stop phase and drop a write
    plan.push_back('{mk_start(CMD_START_RD, 7'd5, 8'd0), 1'b1, out_item_t'('0)});
    plan.push_back('{mk_event(1'b0, 1'b0, 1'b1, 3'd0, 8'h00), 1'b0, out_item_t'('0)});
    plan.push_back('{mk_start(CMD_START_WR, 7'd0, 8'd255), 1'b1, out_item_t'('0)});
    plan.push_back('{mk_event(1'b0, 1'b0, 1'b1, MS_TX_READY, 8'h00), 1'b0, out_item_t'('0)});
    plan.push_back('{mk_event(1'b0, 1'b0, 1'b1, MS_TX_READY, 8'h00), 1'b0, out_item_t'('0)});
    plan.push_back('{mk_event(1'b0, 1'b0, 1'b1, MS_RX_READY, 8'h00), 1'b0, out_item_t'('0)});

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) send_beat(plan[i].beat, plan[i].typed, plan[i].res);
    repeat (RANDOM_BEATS) send_beat(draw_beat(), 1'b0, out_item_t'('0));
    in_valid <= 1'b0;

    // drain, then give stray results a chance to show up
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
